@@ hw/rtl/ycc_pkg.sv @@
// Shared types and constants for the YCbCr 4:2:2 to RGB converter.
// No dependencies; the front, lane, merge and top-level files import this package.
package ycc_pkg;

   // One lane per result pixel that a single request can cause.
   localparam int NumLanes = 4;
   localparam int CntW     = $clog2(NumLanes + 1);
   localparam int IdxW     = $clog2(NumLanes);

   // BT.601 coefficients in 16-bit fixed point, as signed multiplier operands.
   localparam logic signed [17:0] CoefRedCr   = 18'sd89831;
   localparam logic signed [17:0] CoefGreenCr = 18'sd45757;
   localparam logic signed [17:0] CoefGreenCb = 18'sd22050;
   localparam logic signed [17:0] CoefBlueCb  = 18'sd113538;
   localparam logic signed [8:0]  ChromaZero  = 9'sd128;
   localparam int ProdW = 27;
   localparam int FracW = 16;

   // One pixel waiting for conversion, with its result flags.
   typedef struct packed {
      logic [7:0] y;
      logic [7:0] cb;
      logic [7:0] cr;
      logic       last_of_run;
      logic       line_done;
   } pix_type;

   // Converted components of one pixel.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // One result pixel as it leaves the block.
   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last_of_run;
      logic       line_done;
   } out_type;

   // All pixels caused by one request, filled from lane 0 upward.
   typedef struct packed {
      pix_type [NumLanes-1:0] pix;
      logic [CntW-1:0]        count;
   } bundle_type;

   // Status of the front stage.
   typedef struct packed {
      logic s1_valid;
      logic holding;
   } front_status_type;

   // Pipeline advance controls from the merge stage.
   typedef struct packed {
      logic s1_ready;
      logic s2_load;
   } pipe_ctrl_type;

endpackage

@@ hw/rtl/ycc_req_if.sv @@
// Request channel of the converter: one YCbCr item with valid/ready.
// Depends on nothing.
interface ycc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] luma_first;
   logic [7:0] luma_second;
   logic [7:0] chroma_blue;
   logic [7:0] chroma_red;
   logic       line_end;

   modport source (output valid, output luma_first, output luma_second,
                   output chroma_blue, output chroma_red, output line_end,
                   input ready);
   modport sink (input valid, input luma_first, input luma_second,
                 input chroma_blue, input chroma_red, input line_end,
                 output ready);
endinterface

@@ hw/rtl/ycc_rsp_if.sv @@
// Result channel of the converter: one RGB pixel with valid/ready.
// Depends on nothing.
interface ycc_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic       last_of_run;
   logic       line_done;

   modport source (output valid, output red, output green, output blue,
                   output last_of_run, output line_done, input ready);
   modport sink (input valid, input red, input green, input blue,
                 input last_of_run, input line_done, output ready);
endinterface

@@ hw/rtl/ycc_csr_if.sv @@
// Configuration write channel of the converter: the chroma mode register.
// Depends on nothing.
interface ycc_csr_if;
   logic valid;
   logic ready;
   logic chroma_mode;

   modport source (output valid, output chroma_mode, input ready);
   modport sink (input valid, input chroma_mode, output ready);
endinterface

@@ hw/rtl/ycc_front.sv @@
// Front stage: held 4:2:2 pair, chroma averaging and per-request pixel bundle.
// Depends on ycc_pkg and ycc_req_if.
module ycc_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mode,
   ycc_req_if.sink                   req,
   input  logic                      s1_ready,
   output ycc_pkg::bundle_type       bundle,
   output ycc_pkg::front_status_type status
);
   import ycc_pkg::*;

   logic [7:0] held_y0_ff, held_y0_in;
   logic [7:0] held_y1_ff, held_y1_in;
   logic [7:0] held_cb_ff, held_cb_in;
   logic [7:0] held_cr_ff, held_cr_in;
   logic       holding_ff, holding_in;
   logic       s1_valid_ff, s1_valid_in;
   bundle_type bundle_ff, bundle_in;
   logic       accept;
   pix_type    old0, old1, new0, new1;

   function automatic logic [7:0] avg_round(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b} + 9'd1;
      return sum[8:1];
   endfunction

   assign accept    = req.valid && req.ready;
   assign req.ready = !s1_valid_ff || s1_ready;

   // Candidate pixels: the held pair and the new pair.
   always_comb begin
      old0             = '0;
      old0.y           = held_y0_ff;
      old0.cb          = held_cb_ff;
      old0.cr          = held_cr_ff;
      old1             = '0;
      old1.y           = held_y1_ff;
      old1.cb          = avg_round(held_cb_ff, req.chroma_blue);
      old1.cr          = avg_round(held_cr_ff, req.chroma_red);
      new0             = '0;
      new0.y           = req.luma_first;
      new0.cb          = req.chroma_blue;
      new0.cr          = req.chroma_red;
      new1             = new0;
      new1.y           = req.luma_second;
      new1.line_done   = 1'b1;
   end

   // Bundle of results for this request and next held state.
   always_comb begin
      bundle_in  = '0;
      held_y0_in = held_y0_ff;
      held_y1_in = held_y1_ff;
      held_cb_in = held_cb_ff;
      held_cr_in = held_cr_ff;
      holding_in = holding_ff;
      if (!mode) begin
         bundle_in.pix[0]           = new0;
         bundle_in.pix[0].line_done = req.line_end;
         bundle_in.count            = CntW'(1);
      end else begin
         case ({holding_ff, req.line_end})
            2'b11: begin
               bundle_in.pix[0] = old0;
               bundle_in.pix[1] = old1;
               bundle_in.pix[2] = new0;
               bundle_in.pix[3] = new1;
               bundle_in.count  = CntW'(4);
            end
            2'b10: begin
               bundle_in.pix[0] = old0;
               bundle_in.pix[1] = old1;
               bundle_in.count  = CntW'(2);
            end
            2'b01: begin
               bundle_in.pix[0] = new0;
               bundle_in.pix[1] = new1;
               bundle_in.count  = CntW'(2);
            end
            default: begin
               bundle_in.count = '0;
            end
         endcase
      end
      // Mark the final pixel of the run.
      case (bundle_in.count)
         CntW'(1): bundle_in.pix[0].last_of_run = 1'b1;
         CntW'(2): bundle_in.pix[1].last_of_run = 1'b1;
         CntW'(4): bundle_in.pix[3].last_of_run = 1'b1;
         default: ;
      endcase
      if (accept) begin
         if (!mode || req.line_end) begin
            holding_in = 1'b0;
         end else begin
            held_y0_in = req.luma_first;
            held_y1_in = req.luma_second;
            held_cb_in = req.chroma_blue;
            held_cr_in = req.chroma_red;
            holding_in = 1'b1;
         end
      end
   end

   // Stage register valid: a request that causes no result is dropped here.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = (bundle_in.count != '0);
      end else if (s1_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         holding_ff  <= 1'b0;
         s1_valid_ff <= 1'b0;
      end else begin
         holding_ff  <= holding_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      held_y0_ff <= held_y0_in;
      held_y1_ff <= held_y1_in;
      held_cb_ff <= held_cb_in;
      held_cr_ff <= held_cr_in;
      if (accept) begin
         bundle_ff <= bundle_in;
      end
   end

   assign bundle          = bundle_ff;
   assign status.s1_valid = s1_valid_ff;
   assign status.holding  = holding_ff;

endmodule

@@ hw/rtl/ycc_lane.sv @@
// One conversion lane: registered coefficient products, then sum and saturate.
// Depends on ycc_pkg.
module ycc_lane (
   input  logic              clock,
   input  logic              load,
   input  ycc_pkg::pix_type  pix,
   output ycc_pkg::rgb_type  rgb
);
   import ycc_pkg::*;

   logic signed [8:0]       d, e;
   logic signed [ProdW-1:0] prod_r_ff, prod_r_in;
   logic signed [ProdW-1:0] prod_gd_ff, prod_gd_in;
   logic signed [ProdW-1:0] prod_ge_ff, prod_ge_in;
   logic signed [ProdW-1:0] prod_b_ff, prod_b_in;
   logic [7:0]              y_ff;
   logic signed [ProdW-1:0] sum_g;

   // Quotient by 65536, truncated toward zero.
   function automatic logic signed [ProdW-FracW-1:0] trunc_div(
      input logic signed [ProdW-1:0] x);
      logic signed [ProdW-FracW-1:0] q;
      q = x[ProdW-1:FracW];
      if (x[ProdW-1] && (x[FracW-1:0] != '0)) begin
         q = q + (ProdW-FracW)'(1);
      end
      return q;
   endfunction

   // Luma plus or minus a correction, saturated to 0..255.
   function automatic logic [7:0] sat_add(input logic [7:0] y,
                                          input logic signed [ProdW-FracW-1:0] q,
                                          input logic negate);
      logic signed [ProdW-FracW+1:0] s;
      logic signed [ProdW-FracW+1:0] qx;
      qx = (ProdW-FracW+2)'(q);
      s  = $signed({{(ProdW-FracW-6){1'b0}}, y});
      s  = negate ? (s - qx) : (s + qx);
      if (s < 0) begin
         return 8'd0;
      end else if (s > $signed((ProdW-FracW+2)'(255))) begin
         return 8'd255;
      end
      return s[7:0];
   endfunction

   // Chroma offsets and products.
   always_comb begin
      d          = $signed({1'b0, pix.cr}) - ChromaZero;
      e          = $signed({1'b0, pix.cb}) - ChromaZero;
      prod_r_in  = d * CoefRedCr;
      prod_gd_in = d * CoefGreenCr;
      prod_ge_in = e * CoefGreenCb;
      prod_b_in  = e * CoefBlueCb;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         prod_r_ff  <= prod_r_in;
         prod_gd_ff <= prod_gd_in;
         prod_ge_ff <= prod_ge_in;
         prod_b_ff  <= prod_b_in;
         y_ff       <= pix.y;
      end
   end

   // Scale, add to luma and saturate.
   always_comb begin
      sum_g     = prod_gd_ff + prod_ge_ff;
      rgb.red   = sat_add(y_ff, trunc_div(prod_r_ff), 1'b0);
      rgb.green = sat_add(y_ff, trunc_div(sum_g), 1'b1);
      rgb.blue  = sat_add(y_ff, trunc_div(prod_b_ff), 1'b0);
   end

endmodule

@@ hw/rtl/ycc_merge.sv @@
// Merge stage: collects the lane results of one request and sends them out
// one pixel a cycle while rsp.ready is high. Depends on ycc_pkg and ycc_rsp_if.
module ycc_merge (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  s1_valid,
   input  ycc_pkg::bundle_type                   bundle,
   input  ycc_pkg::rgb_type [ycc_pkg::NumLanes-1:0] lane_rgb,
   output ycc_pkg::pipe_ctrl_type                ctrl,
   ycc_rsp_if.source                             rsp
);
   import ycc_pkg::*;

   logic                    s2_valid_ff, s2_valid_in;
   logic [CntW-1:0]         s2_cnt_ff;
   logic [NumLanes-1:0]     s2_last_ff, s2_done_ff;
   logic                    s3_valid_ff, s3_valid_in;
   logic [CntW-1:0]         s3_cnt_ff;
   logic [IdxW-1:0]         s3_idx_ff, s3_idx_in;
   out_type [NumLanes-1:0]  s3_res_ff;
   logic                    take, take_last, s3_free, s2_move;
   out_type                 cur;

   // Output serializer handshake.
   assign take      = s3_valid_ff && rsp.ready;
   assign take_last = take && ((CntW'(s3_idx_ff) + CntW'(1)) == s3_cnt_ff);
   assign s3_free   = !s3_valid_ff || take_last;
   assign s2_move   = s2_valid_ff && s3_free;

   assign ctrl.s1_ready = !s2_valid_ff || s3_free;
   assign ctrl.s2_load  = s1_valid && ctrl.s1_ready;

   // Valid and index updates.
   always_comb begin
      s2_valid_in = s2_valid_ff;
      if (ctrl.s2_load) begin
         s2_valid_in = 1'b1;
      end else if (s2_move) begin
         s2_valid_in = 1'b0;
      end
      s3_valid_in = s3_valid_ff;
      s3_idx_in   = s3_idx_ff;
      if (s2_move) begin
         s3_valid_in = 1'b1;
         s3_idx_in   = '0;
      end else if (take_last) begin
         s3_valid_in = 1'b0;
      end else if (take) begin
         s3_idx_in = s3_idx_ff + IdxW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s3_idx_ff   <= '0;
      end else begin
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s3_idx_ff   <= s3_idx_in;
      end
   end

   // Request metadata alongside the lane product registers, then results.
   always_ff @(posedge clock) begin
      if (ctrl.s2_load) begin
         s2_cnt_ff <= bundle.count;
         for (int i = 0; i < NumLanes; i++) begin
            s2_last_ff[i] <= bundle.pix[i].last_of_run;
            s2_done_ff[i] <= bundle.pix[i].line_done;
         end
      end
      if (s2_move) begin
         s3_cnt_ff <= s2_cnt_ff;
         for (int i = 0; i < NumLanes; i++) begin
            s3_res_ff[i].red         <= lane_rgb[i].red;
            s3_res_ff[i].green       <= lane_rgb[i].green;
            s3_res_ff[i].blue        <= lane_rgb[i].blue;
            s3_res_ff[i].last_of_run <= s2_last_ff[i];
            s3_res_ff[i].line_done   <= s2_done_ff[i];
         end
      end
   end

   // Present the current pixel.
   assign cur             = s3_res_ff[s3_idx_ff];
   assign rsp.valid       = s3_valid_ff;
   assign rsp.red         = cur.red;
   assign rsp.green       = cur.green;
   assign rsp.blue        = cur.blue;
   assign rsp.last_of_run = cur.last_of_run;
   assign rsp.line_done   = cur.line_done;

endmodule

@@ hw/rtl/ycbcr422_to_rgb_converter.sv @@
// YCbCr 4:4:4 / 4:2:2 to RGB converter, top level.
// Path: a request passes the front bundle register, the lane product registers
// and the merge result register before its first result is presented.
// Throughput: one result pixel per cycle from the output serializer when not
// stalled; a request gives 1, 2 or 4 (a 4:2:2 line start with nothing held, none).
// Reset: synchronous, active high; clears the mode register, the held pair flag
// and all pipeline valids. Depends on ycc_pkg, the channel interfaces,
// ycc_front, ycc_lane and ycc_merge.
module ycbcr422_to_rgb_converter (
   input  logic      clock,
   input  logic      reset,
   ycc_req_if.sink   req,
   ycc_rsp_if.source rsp,
   ycc_csr_if.sink   csr
);
   import ycc_pkg::*;

   logic                   mode_ff, mode_in;
   bundle_type             bundle;
   front_status_type       status;
   pipe_ctrl_type          ctrl;
   rgb_type [NumLanes-1:0] lane_rgb;

   // Chroma mode register; writes are always taken.
   assign csr.ready = 1'b1;
   assign mode_in   = (csr.valid && csr.ready) ? csr.chroma_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   // Front stage with held pair.
   ycc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .mode     (mode_ff),
      .req      (req),
      .s1_ready (ctrl.s1_ready),
      .bundle   (bundle),
      .status   (status)
   );

   // Conversion lanes, one per pixel of the bundle.
   for (genvar i = 0; i < NumLanes; i++) begin : g_lane
      ycc_lane u_lane (
         .clock (clock),
         .load  (ctrl.s2_load),
         .pix   (bundle.pix[i]),
         .rgb   (lane_rgb[i])
      );
   end

   // Merge and output serializer.
   ycc_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (status.s1_valid),
      .bundle   (bundle),
      .lane_rgb (lane_rgb),
      .ctrl     (ctrl),
      .rsp      (rsp)
   );

   // The end of a line is always the final pixel of its request.
   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.line_done) |-> rsp.last_of_run)
      else $error("line_done without last_of_run");

   // No result is presented in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp.valid)
      else $error("result valid right after reset");

   // A 4:2:2 line start with nothing held produces no pixels.
   a_line_start_silent: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && mode_ff && !status.holding && !req.line_end)
      |=> !status.s1_valid)
      else $error("pixels produced for an unpaired line start");

endmodule

@@ dv/ycc_rgb_check.sv @@
// Result checking for the YCbCr to RGB converter: predicts the RGB pixels of every
// accepted request and compares them, in order, with the result channel.
// Depends on ycc_pkg and the request, result and configuration interfaces.
module ycc_rgb_check (
   input  logic clock,
   input  logic reset,
   ycc_req_if   req,
   ycc_rsp_if   rsp,
   ycc_csr_if   csr,
   output int   errors,
   output int   pending,
   output int   checked
);

   // BT.601 coefficients in 16-bit fixed point and the chroma offset.
   localparam int RedFromCr    = 89831;
   localparam int GreenFromCr  = 45757;
   localparam int GreenFromCb  = 22050;
   localparam int BlueFromCb   = 113538;
   localparam int FracScale    = 65536;
   localparam int ChromaOffset = 128;
   localparam int ComponentMax = 255;

   // Shadow of the mode register and of the held 4:2:2 pair.
   logic       pairs_mode;
   logic       holding;
   logic [7:0] held_y0;
   logic [7:0] held_y1;
   logic [7:0] held_cb;
   logic [7:0] held_cr;

   ycc_pkg::out_type expected_pixels[$];
   int               fail_count;
   int               pixel_count;

   initial begin
      errors      = 0;
      pending     = 0;
      checked     = 0;
      fail_count  = 0;
      pixel_count = 0;
   end

   // Saturate a component to the 8-bit range.
   function automatic logic [7:0] sat8(input int v);
      if (v < 0) begin
         return 8'd0;
      end
      if (v > ComponentMax) begin
         return 8'd255;
      end
      return 8'(v);
   endfunction

   // Rounded average of two chroma samples.
   function automatic logic [7:0] avg_chroma(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] sum;
      sum = {1'b0, a} + {1'b0, b} + 9'd1;
      return sum[8:1];
   endfunction

   // Convert one pixel; integer division truncates toward zero. Flags start at zero.
   function automatic ycc_pkg::out_type convert_pixel(input logic [7:0] y,
                                                      input logic [7:0] cb,
                                                      input logic [7:0] cr);
      ycc_pkg::out_type px;
      int               e;
      int               d;
      e = int'(cb) - ChromaOffset;
      d = int'(cr) - ChromaOffset;
      px.red         = sat8(int'(y) + (d * RedFromCr) / FracScale);
      px.green       = sat8(int'(y) - (d * GreenFromCr + e * GreenFromCb) / FracScale);
      px.blue        = sat8(int'(y) + (e * BlueFromCb) / FracScale);
      px.last_of_run = 1'b0;
      px.line_done   = 1'b0;
      return px;
   endfunction

   // Work out the pixels that one accepted request causes.
   task automatic predict_pixels(input logic [7:0] y0, input logic [7:0] y1,
                                 input logic [7:0] cb, input logic [7:0] cr,
                                 input logic eol);
      ycc_pkg::out_type px;
      if (!pairs_mode) begin
         // A 4:4:4 request drops any held pair.
         holding        = 1'b0;
         px             = convert_pixel(y0, cb, cr);
         px.last_of_run = 1'b1;
         px.line_done   = eol;
         expected_pixels.push_back(px);
      end else begin
         // The held pair goes out first, its second pixel with averaged chroma.
         if (holding) begin
            expected_pixels.push_back(convert_pixel(held_y0, held_cb, held_cr));
            px = convert_pixel(held_y1, avg_chroma(held_cb, cb), avg_chroma(held_cr, cr));
            px.last_of_run = !eol;
            expected_pixels.push_back(px);
         end
         // At line end the new pair goes out with its own chroma; otherwise it is held.
         if (eol) begin
            expected_pixels.push_back(convert_pixel(y0, cb, cr));
            px             = convert_pixel(y1, cb, cr);
            px.last_of_run = 1'b1;
            px.line_done   = 1'b1;
            expected_pixels.push_back(px);
            holding = 1'b0;
         end else begin
            held_y0 = y0;
            held_y1 = y1;
            held_cb = cb;
            held_cr = cr;
            holding = 1'b1;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Compare one accepted result pixel with the oldest expected one.
   task automatic compare_pixel();
      ycc_pkg::out_type want;
      if (expected_pixels.size() == 0) begin
         $error("result pixel with nothing expected: red %0d, green %0d, blue %0d",
                rsp.red, rsp.green, rsp.blue);
         fail_count++;
         return;
      end
      want = expected_pixels.pop_front();
      pixel_count++;
      check_field("red", want.red, rsp.red);
      check_field("green", want.green, rsp.green);
      check_field("blue", want.blue, rsp.blue);
      check_field("last_of_run", {7'd0, want.last_of_run}, {7'd0, rsp.last_of_run});
      check_field("line_done", {7'd0, want.line_done}, {7'd0, rsp.line_done});
   endtask

   // Results are handled before new requests, since a request never causes a
   // result at the edge of its own acceptance.
   always @(posedge clock) begin
      if (reset) begin
         pairs_mode = 1'b0;
         holding    = 1'b0;
         held_y0    = 8'd0;
         held_y1    = 8'd0;
         held_cb    = 8'd0;
         held_cr    = 8'd0;
         expected_pixels.delete();
      end else begin
         if (rsp.valid && rsp.ready) begin
            compare_pixel();
         end
         if (csr.valid && csr.ready) begin
            pairs_mode = csr.chroma_mode;
         end
         if (req.valid && req.ready) begin
            predict_pixels(req.luma_first, req.luma_second, req.chroma_blue,
                           req.chroma_red, req.line_end);
         end
      end
      errors  <= fail_count;
      pending <= expected_pixels.size();
      checked <= pixel_count;
   end

endmodule

@@ dv/testbench.sv @@
// Top of the converter regression: clock, reset, request and mode stimulus,
// output stalls and the verdict. Depends on ycc_pkg, the channel interfaces,
// ycbcr422_to_rgb_converter and ycc_rgb_check.
module testbench;

   localparam logic Mode444       = 1'b0;
   localparam logic Mode422       = 1'b1;
   localparam int   DrainPause    = 8;
   localparam int   TailCycles    = 20;
   localparam int   HoldOffCycles = 200;
   localparam int   ResetCycles   = 11;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_off;
   logic current_mode;
   int   send_idle_pct;
   int   recv_stall_pct;
   int   sent_items;
   int   sent_pairs;
   int   mode_writes;
   int   errors;
   int   pending;
   int   checked;

   ycc_req_if req_ch();
   ycc_rsp_if rsp_ch();
   ycc_csr_if csr_ch();

   ycbcr422_to_rgb_converter u_top (
      .clock(clock),
      .reset(reset),
      .req  (req_ch),
      .rsp  (rsp_ch),
      .csr  (csr_ch)
   );

   ycc_rgb_check u_rgb_check (
      .clock  (clock),
      .reset  (reset),
      .req    (req_ch),
      .rsp    (rsp_ch),
      .csr    (csr_ch),
      .errors (errors),
      .pending(pending),
      .checked(checked)
   );

   always #5 clock = ~clock;

   // Output side: random stalls, or a solid hold-off while one is running.
   always @(posedge clock) begin
      rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
   end

   // Mostly random bytes, with the extremes favored.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Offer one request after random idle cycles and wait for its acceptance.
   task automatic send_request(input logic [7:0] y0, input logic [7:0] y1,
                               input logic [7:0] cb, input logic [7:0] cr,
                               input logic eol);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.luma_first  <= y0;
      req_ch.luma_second <= y1;
      req_ch.chroma_blue <= cb;
      req_ch.chroma_red  <= cr;
      req_ch.line_end    <= eol;
      do @(posedge clock); while (!req_ch.ready);
      sent_items++;
      if (current_mode == Mode422) begin
         sent_pairs++;
      end
   endtask

   // Stop offering requests, wait for every expected pixel, then pause; a held
   // line start stays held inside the block.
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (DrainPause) @(posedge clock);
   endtask

   // Write the mode register once the block is idle.
   task automatic write_mode(input logic mode);
      drain_pipeline();
      csr_ch.valid       <= 1'b1;
      csr_ch.chroma_mode <= mode;
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      current_mode = mode;
      mode_writes++;
   endtask

   // 4:2:2 lines of random length; now and then a line end is flipped.
   task automatic run_pair_lines(input int budget);
      int   count;
      int   len;
      logic eol;
      count = 0;
      while (count < budget) begin
         len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 8);
         for (int k = 0; k < len; k++) begin
            eol = (k == len - 1);
            if ($urandom_range(19) == 0) begin
               eol = ~eol;
            end
            send_request(pick_byte(), pick_byte(), pick_byte(), pick_byte(), eol);
         end
         count += len;
      end
   endtask

   // 4:4:4 pixels with random line ends.
   task automatic run_pixels(input int budget);
      for (int k = 0; k < budget; k++) begin
         send_request(pick_byte(), pick_byte(), pick_byte(), pick_byte(),
                      $urandom_range(7) == 0);
      end
   endtask

   initial begin
      req_ch.valid       = 1'b0;
      req_ch.luma_first  = 8'd0;
      req_ch.luma_second = 8'd0;
      req_ch.chroma_blue = 8'd0;
      req_ch.chroma_red  = 8'd0;
      req_ch.line_end    = 1'b0;
      rsp_ch.ready       = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.chroma_mode = Mode444;
      hold_off           = 1'b0;
      current_mode       = Mode444;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      sent_items         = 0;
      sent_pairs         = 0;
      mode_writes        = 0;

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // Directed 4:4:4 pixels: component extremes and neutral chroma.
      write_mode(Mode444);
      send_request(8'h00, 8'hFF, 8'h00, 8'h00, 1'b0);
      send_request(8'hFF, 8'h00, 8'hFF, 8'hFF, 1'b1);
      send_request(8'h00, 8'h55, 8'hFF, 8'h00, 1'b0);
      send_request(8'hFF, 8'hAA, 8'h00, 8'hFF, 1'b0);
      send_request(8'h80, 8'h80, 8'h80, 8'h80, 1'b1);

      // Directed 4:2:2: a one-request line, then a line of three requests.
      write_mode(Mode422);
      send_request(8'h00, 8'hFF, 8'h00, 8'hFF, 1'b1);
      send_request(8'hFF, 8'h00, 8'hFF, 8'h00, 1'b0);
      send_request(8'h0A, 8'hC8, 8'h80, 8'h80, 1'b0);
      send_request(8'h33, 8'hEE, 8'h01, 8'hFE, 1'b1);

      // Rewriting the mode keeps the held pair.
      send_request(8'h7F, 8'h81, 8'hFE, 8'h01, 1'b0);
      write_mode(Mode422);
      send_request(8'h10, 8'hEB, 8'h7F, 8'h81, 1'b1);
      send_request(8'hEB, 8'h10, 8'h00, 8'hFF, 1'b0);
      write_mode(Mode444);
      write_mode(Mode422);
      send_request(8'h40, 8'hC0, 8'hFF, 8'h00, 1'b0);

      // A 4:4:4 request drops the held pair.
      write_mode(Mode444);
      send_request(8'h20, 8'h00, 8'h60, 8'hA0, 1'b0);
      send_request(8'hE0, 8'hFF, 8'hA0, 8'h60, 1'b1);
      write_mode(Mode422);
      send_request(8'h01, 8'hFE, 8'h02, 8'hFD, 1'b0);
      send_request(8'hFE, 8'h01, 8'hFD, 8'h02, 1'b1);

      // Random phases: none idle, sender idle, receiver stalling, both.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_idle_pct = 48;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct = 0;
               recv_stall_pct <= 48;
            end
            default: begin
               send_idle_pct = 19;
               recv_stall_pct <= 19;
            end
         endcase
         write_mode(Mode422);
         // Hold the output off while requests keep coming, so the block backs up.
         if (phase == 0) begin
            fork
               begin
                  hold_off <= 1'b1;
                  repeat (HoldOffCycles) @(posedge clock);
                  hold_off <= 1'b0;
               end
            join_none
         end
         run_pair_lines(80);
         write_mode(Mode444);
         run_pixels(35);
      end

      drain_pipeline();
      repeat (TailCycles) @(posedge clock);

      $display("Covered %0d requests (%0d as 4:2:2 pairs) and %0d mode writes;",
               sent_items, sent_pairs, mode_writes);
      $display("compared %0d pixels under four idling patterns and one output hold-off.",
               checked);
      if (errors == 0 && pending == 0) begin
         $display("ycbcr422_to_rgb_converter regression: pass");
      end else begin
         $display("ycbcr422_to_rgb_converter regression: fail");
      end
      $finish;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #1000000;
      $display("Run limit reached with %0d pixels still expected.", pending);
      $display("ycbcr422_to_rgb_converter regression: fail");
      $finish;
   end

endmodule

@@ ycbcr422_to_rgb_converter.f @@
hw/rtl/ycc_pkg.sv
hw/rtl/ycc_req_if.sv
hw/rtl/ycc_rsp_if.sv
hw/rtl/ycc_csr_if.sv
hw/rtl/ycc_front.sv
hw/rtl/ycc_lane.sv
hw/rtl/ycc_merge.sv
hw/rtl/ycbcr422_to_rgb_converter.sv
dv/ycc_rgb_check.sv
dv/testbench.sv
